>>> rtl/frp_pkg.sv
// Package for the FASTA record parser: byte codes, phase and result-kind codes,
// description counter sizing and the result record type.
// No dependencies; every other file of the block imports it.
package frp_pkg;

  localparam int LEN_W = 32;
  localparam int DESC_MAX = 256;
  localparam int DESC_CW = $clog2(DESC_MAX + 2);
  localparam logic [DESC_CW-1:0] DESC_LIM = DESC_CW'(DESC_MAX);
  localparam logic [DESC_CW-1:0] DESC_SAT = DESC_CW'(DESC_MAX + 1);

  localparam logic [7:0] CH_START = 8'h3E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [1:0] PH_EXPECT = 2'd0;
  localparam logic [1:0] PH_DESC = 2'd1;
  localparam logic [1:0] PH_SEQ = 2'd2;
  localparam logic [1:0] PH_ERROR = 2'd3;

  localparam logic [2:0] K_DESC_BYTE = 3'd0;
  localparam logic [2:0] K_DESC_END = 3'd1;
  localparam logic [2:0] K_RESIDUE = 3'd2;
  localparam logic [2:0] K_RECORD_END = 3'd3;
  localparam logic [2:0] K_STREAM_END = 3'd4;
  localparam logic [2:0] K_ERROR = 3'd5;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NO_START = 2'd1;
  localparam logic [1:0] ERR_EOS_IN_DESC = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] length;
    logic             desc_truncated;
    logic [1:0]       error_code;
    logic             last;
  } frp_result_t;

  typedef struct packed {
    logic [1:0]  n;
    frp_result_t res0;
    frp_result_t res1;
  } frp_push_t;

endpackage

>>> rtl/frp_ifs.sv
// Channel interfaces of the FASTA record parser: input bytes and result records.
// Depends on frp_pkg for the field widths.
interface frp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface frp_out_if import frp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [7:0]       out_byte;
  logic [LEN_W-1:0] length;
  logic             desc_truncated;
  logic [1:0]       error_code;
  logic             last;

  modport source (output valid, output kind, output out_byte, output length,
                  output desc_truncated, output error_code, output last, input ready);
  modport sink (input valid, input kind, input out_byte, input length,
                input desc_truncated, input error_code, input last, output ready);
endinterface

>>> rtl/frp_parser.sv
// Input register, parse state and the combinational step that turns one byte
// into zero, one or two result records. Depends on frp_pkg and frp_in_if.
module frp_parser import frp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  frp_in_if.sink     in_ch,
  input  logic       space_ok,
  output frp_push_t  push
);

  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  logic               in_eos_r;
  logic [1:0]         phase_r, phase_nxt;
  logic [DESC_CW-1:0] desc_count_r, desc_count_nxt;
  logic [LEN_W-1:0]   residue_count_r, residue_count_nxt;
  logic [1:0]         err_code_r, err_code_nxt;
  logic               adv;
  logic [1:0]         n;
  frp_result_t        r0, r1;
  logic [DESC_CW-1:0] desc_inc;
  logic [DESC_CW-1:0] stored;

  assign adv = in_valid_r && space_ok;
  assign in_ch.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.data_byte;
      in_eos_r  <= in_ch.end_of_stream;
    end
  end

  assign desc_inc = (desc_count_r == DESC_SAT) ? desc_count_r : desc_count_r + 1'b1;
  assign stored = (desc_count_r > DESC_LIM) ? DESC_LIM : desc_count_r;

  always_comb begin
    phase_nxt = phase_r;
    desc_count_nxt = desc_count_r;
    residue_count_nxt = residue_count_r;
    err_code_nxt = err_code_r;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    case (phase_r)
      PH_EXPECT: begin
        n = 2'd1;
        if (in_eos_r) begin
          r0.kind = K_STREAM_END;
        end else if (in_byte_r == CH_START) begin
          desc_count_nxt = DESC_CW'(1);
          phase_nxt = PH_DESC;
          r0.kind = K_DESC_BYTE;
          r0.out_byte = in_byte_r;
        end else begin
          err_code_nxt = ERR_NO_START;
          phase_nxt = PH_ERROR;
          r0.kind = K_ERROR;
          r0.error_code = ERR_NO_START;
        end
      end
      PH_DESC: begin
        if (in_eos_r) begin
          n = 2'd1;
          err_code_nxt = ERR_EOS_IN_DESC;
          phase_nxt = PH_ERROR;
          r0.kind = K_ERROR;
          r0.error_code = ERR_EOS_IN_DESC;
        end else if (in_byte_r == CH_NEWLINE) begin
          n = 2'd1;
          residue_count_nxt = '0;
          phase_nxt = PH_SEQ;
          r0.kind = K_DESC_END;
          r0.length = {{(LEN_W-DESC_CW){1'b0}}, stored};
          r0.desc_truncated = desc_count_r > DESC_LIM;
        end else begin
          desc_count_nxt = desc_inc;
          if (desc_inc <= DESC_LIM) begin
            n = 2'd1;
            r0.kind = K_DESC_BYTE;
            r0.out_byte = in_byte_r;
          end
        end
      end
      PH_SEQ: begin
        if (in_eos_r) begin
          n = 2'd2;
          r0.kind = K_RECORD_END;
          r0.length = residue_count_r;
          r1.kind = K_STREAM_END;
          residue_count_nxt = '0;
          desc_count_nxt = '0;
          phase_nxt = PH_EXPECT;
        end else if (in_byte_r == CH_START) begin
          n = 2'd2;
          r0.kind = K_RECORD_END;
          r0.length = residue_count_r;
          r1.kind = K_DESC_BYTE;
          r1.out_byte = in_byte_r;
          residue_count_nxt = '0;
          desc_count_nxt = DESC_CW'(1);
          phase_nxt = PH_DESC;
        end else if (!(in_byte_r inside {8'h20, [8'h09:8'h0D]})) begin
          n = 2'd1;
          residue_count_nxt = (&residue_count_r) ? residue_count_r
                                                 : residue_count_r + 1'b1;
          r0.kind = K_RESIDUE;
          r0.out_byte = in_byte_r;
        end
      end
      default: begin
        n = 2'd1;
        r0.kind = K_ERROR;
        r0.error_code = err_code_r;
      end
    endcase
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_EXPECT;
      desc_count_r <= '0;
      residue_count_r <= '0;
      err_code_r <= ERR_NONE;
    end else if (adv) begin
      phase_r <= phase_nxt;
      desc_count_r <= desc_count_nxt;
      residue_count_r <= residue_count_nxt;
      err_code_r <= err_code_nxt;
    end
  end

  assign push.n = adv ? n : 2'd0;
  assign push.res0 = r0;
  assign push.res1 = r1;

endmodule

>>> rtl/frp_outq.sv
// Four-entry result queue that takes up to two records a cycle and hands one
// record a cycle to out_ch while it is ready. Depends on frp_pkg, frp_out_if.
module frp_outq import frp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  frp_push_t push,
  output logic      space_ok,
  frp_out_if.source out_ch
);

  frp_result_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;
  frp_result_t       head;

  assign pop = out_ch.valid && out_ch.ready;
  assign space_ok = count_r <= QCNT_W'(QDEPTH - 2);
  assign count_nxt = count_r + QCNT_W'(push.n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push.n);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(pop);
      count_r <= count_nxt;
    end
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + 1'b1] <= push.res1;
    end
  end

  assign head = mem_r[rd_ptr_r];
  assign out_ch.valid = count_r != '0;
  assign out_ch.kind = head.kind;
  assign out_ch.out_byte = head.out_byte;
  assign out_ch.length = head.length;
  assign out_ch.desc_truncated = head.desc_truncated;
  assign out_ch.error_code = head.error_code;
  assign out_ch.last = head.last;

endmodule

>>> rtl/fasta_record_parser_top.sv
// Top level of the FASTA record parser: the parse stage feeding the result queue.
// Depends on frp_pkg, frp_ifs, frp_parser and frp_outq.
//
//   Channel  Direction  Carries
//   in_ch    sink       data_byte, end_of_stream
//   out_ch   source     kind, out_byte, length, desc_truncated, error_code, last
//
// One input byte is accepted per cycle while the four-entry result queue has
// room for two records; each accepted byte is held in the input register and
// parsed from there. A byte gives zero, one or two records, and the output
// side delivers one record per cycle while out_ch is ready.
// Reset is synchronous and clears the phase, counters and sticky error code.
// Output stalls fill the queue and then hold off input transfers.
module fasta_record_parser_top import frp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  frp_in_if.sink    in_ch,
  frp_out_if.source out_ch
);

  frp_push_t push;
  logic      space_ok;

  frp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .space_ok (space_ok),
    .push     (push)
  );

  frp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

>>> rtl/frp_checker.sv
// Port-level checker for the FASTA record parser and its bind to the top level.
// Depends on frp_pkg and fasta_record_parser_top.
module frp_checker import frp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       kind,
  input logic [LEN_W-1:0] length,
  input logic             desc_truncated,
  input logic [1:0]       error_code
);

  logic seen_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_err_r <= 1'b0;
    end else if (out_valid && out_ready && kind == K_ERROR) begin
      seen_err_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Output record was withdrawn before its transfer.");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_err_r |-> kind == K_ERROR)
    else $error("A non-error record followed an error record.");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((kind == K_ERROR) == (error_code != ERR_NONE)))
    else $error("Error code does not match the record kind.");

  a_len_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != K_DESC_END && kind != K_RECORD_END
      |-> length == '0 && !desc_truncated)
    else $error("Length or truncation set on a record that carries none.");

endmodule

bind fasta_record_parser_top frp_checker u_frp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .kind           (out_ch.kind),
  .length         (out_ch.length),
  .desc_truncated (out_ch.desc_truncated),
  .error_code     (out_ch.error_code)
);
